// File: rtl/ilp_pkg.sv
// Shared types and constants for the integer literal parser.
package ilp_pkg;

    localparam int unsigned MAX_CHARS = 8;
    localparam logic [31:0] MAG_LIMIT = 32'd99999999;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        PH_START,
        PH_SIGNED,
        PH_ZERO,
        PH_DEC,
        PH_HEX,
        PH_BIN
    } phase_t;

    typedef enum logic [1:0] {
        BASE_DEC,
        BASE_HEX,
        BASE_BIN
    } base_t;

    typedef enum logic [1:0] {
        MUL_2,
        MUL_10,
        MUL_16
    } mul_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic signed [27:0] value;
        logic               valid_res;
        base_t              base;
    } out_item_t;

    typedef struct packed {
        phase_t      phase;
        logic        negative;
        logic [26:0] acc;
        base_t       radix;
        logic [3:0]  count;
        logic        bad;
    } tok_state_t;

    localparam tok_state_t TOK_CLEAR = '{
        phase:    PH_START,
        negative: 1'b0,
        acc:      27'd0,
        radix:    BASE_DEC,
        count:    4'd0,
        bad:      1'b0
    };

endpackage

// File: rtl/ilp_step.sv
// Per-character token update and result formation for the integer literal parser.
module ilp_step
    import ilp_pkg::*;
(
    input  tok_state_t state,
    input  in_item_t   item,
    output tok_state_t state_next,
    output out_item_t  res
);

    always_comb
    begin
        tok_state_t  st;
        logic        is_dec;
        logic        is_lhex;
        logic        is_uhex;
        logic        do_add;
        mul_t        mul_sel;
        logic [7:0]  dbyte;
        logic [3:0]  dval;
        logic [31:0] wide_acc;
        logic [31:0] prod;
        logic [31:0] sum;
        logic        ok;
        logic [27:0] mag;
        logic [27:0] sval;

        st      = state;
        do_add  = 1'b0;
        mul_sel = MUL_10;

        is_dec  = (item.ch >= CH_0) && (item.ch <= CH_9);
        is_lhex = (item.ch >= CH_LA) && (item.ch <= CH_LF);
        is_uhex = (item.ch >= CH_UA) && (item.ch <= CH_UF);
        if (is_lhex)
        begin
            dbyte = item.ch - CH_LA + 8'd10;
        end
        else if (is_uhex)
        begin
            dbyte = item.ch - CH_UA + 8'd10;
        end
        else
        begin
            dbyte = item.ch - CH_0;
        end
        dval = dbyte[3:0];

        if (st.count != 4'd15)
        begin
            st.count = st.count + 4'd1;
        end
        if (st.count > 4'(MAX_CHARS))
        begin
            st.bad = 1'b1;
        end

        if (!st.bad)
        begin
            case (st.phase)
                PH_START,
                PH_SIGNED:
                begin
                    if ((st.phase == PH_START) &&
                        ((item.ch == CH_PLUS) || (item.ch == CH_MINUS)))
                    begin
                        st.negative = (item.ch == CH_MINUS);
                        st.phase    = PH_SIGNED;
                    end
                    else if (item.ch == CH_0)
                    begin
                        st.phase = PH_ZERO;
                    end
                    else if (is_dec)
                    begin
                        st.acc   = {23'd0, dval};
                        st.phase = PH_DEC;
                    end
                    else
                    begin
                        st.bad = 1'b1;
                    end
                end
                PH_ZERO:
                begin
                    if ((item.ch == CH_LX) || (item.ch == CH_UX))
                    begin
                        st.radix = BASE_HEX;
                        st.phase = PH_HEX;
                    end
                    else if ((item.ch == CH_LB) || (item.ch == CH_UB))
                    begin
                        st.radix = BASE_BIN;
                        st.phase = PH_BIN;
                    end
                    else if (is_dec)
                    begin
                        do_add   = 1'b1;
                        mul_sel  = MUL_10;
                        st.phase = PH_DEC;
                    end
                    else
                    begin
                        st.bad = 1'b1;
                    end
                end
                PH_DEC:
                begin
                    do_add  = is_dec;
                    mul_sel = MUL_10;
                    st.bad  = !is_dec;
                end
                PH_HEX:
                begin
                    do_add  = is_dec || is_lhex || is_uhex;
                    mul_sel = MUL_16;
                    st.bad  = !(is_dec || is_lhex || is_uhex);
                end
                PH_BIN:
                begin
                    do_add  = (item.ch == CH_0) || (item.ch == CH_1);
                    mul_sel = MUL_2;
                    st.bad  = !do_add;
                end
                default:
                begin
                    st.bad = 1'b1;
                end
            endcase
        end

        wide_acc = {5'd0, state.acc};
        case (mul_sel)
            MUL_2:   prod = wide_acc << 1;
            MUL_16:  prod = wide_acc << 4;
            default: prod = (wide_acc << 3) + (wide_acc << 1);
        endcase
        sum = prod + {28'd0, dval};

        if (do_add)
        begin
            if (sum > MAG_LIMIT)
            begin
                st.bad = 1'b1;
            end
            else
            begin
                st.acc = sum[26:0];
            end
        end

        ok = !st.bad && ((st.phase == PH_ZERO) || (st.phase == PH_DEC) ||
                         (st.phase == PH_HEX) || (st.phase == PH_BIN));
        mag  = {1'b0, st.acc};
        sval = st.negative ? (28'd0 - mag) : mag;

        res.valid_res = ok;
        res.value     = ok ? $signed(sval) : 28'sd0;
        res.base      = ok ? st.radix : BASE_DEC;

        state_next = item.last ? TOK_CLEAR : st;
    end

endmodule

// File: rtl/integer_literal_parser_unit.sv
// Top level of the integer literal parser: token state and output buffering.
// A result is registered into a result entry when its last character is accepted.
// Throughput: one character item per cycle while item_stall is low; the token update is combinational.
// A two-entry result buffer lets input continue while one result waits to be taken.
// item_stall rises only when both result entries are full.
// Reset clears the token state and both result entries.
module integer_literal_parser_unit
    import ilp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    tok_state_t state_reg;
    tok_state_t state_next;
    out_item_t  step_res;
    out_item_t  out_reg;
    out_item_t  skid_reg;
    logic       out_valid_reg;
    logic       skid_valid_reg;
    logic       accept;
    logic       push;
    logic       take;

    ilp_step u_step (
        .state      (state_reg),
        .item       (item),
        .state_next (state_next),
        .res        (step_res)
    );

    assign item_stall   = skid_valid_reg;
    assign accept       = item_valid && !skid_valid_reg;
    assign push         = accept && item.last;
    assign take         = out_valid_reg && !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= TOK_CLEAR;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
            begin
                skid_reg <= step_res;
            end
            else
            begin
                out_reg <= step_res;
            end
        end
    end

endmodule

// File: rtl/ilp_checker.sv
// Port-level assertions for the integer literal parser and their binding.
module ilp_checker
    import ilp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      item_valid,
    input logic      item_stall,
    input in_item_t  item,
    input logic      result_valid,
    input logic      result_stall,
    input out_item_t result
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("Stalled result item changed.");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid)
        else $error("Input stalled while no result item is pending.");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.last && !result_valid |=> result_valid)
        else $error("Last character item produced no result item.");

    a_invalid_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.valid_res |-> (result.value == 28'sd0) &&
            (result.base == BASE_DEC))
        else $error("Invalid result item carries a nonzero value or base.");

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.value <= 28'sd99999999) &&
            (result.value >= -28'sd99999999))
        else $error("Result value outside the allowed magnitude.");

endmodule

bind integer_literal_parser_unit ilp_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
